FILE: rtl/etmf_pkg.sv
// Package for the edge-truncated median filter.
// Holds sizes, the window request type and the front state encoding.
`default_nettype none
package etmf_pkg;

    localparam int HALF_WIDTH  = 3;
    localparam int SAMPLE_BITS = 16;
    localparam int HIST_DEPTH  = 2 * HALF_WIDTH;
    localparam int WIN_MAX     = 2 * HALF_WIDTH + 1;
    localparam int CNT_BITS    = $clog2(WIN_MAX + 1);
    localparam int IDX_BITS    = $clog2(WIN_MAX);
    localparam int EXT_BITS    = SAMPLE_BITS + 1;
    localparam int SORT_STAGES = WIN_MAX;
    localparam int Q_DEPTH     = 4;
    localparam int QPTR_BITS   = $clog2(Q_DEPTH);
    localparam int QCNT_BITS   = $clog2(Q_DEPTH + 1);

    // Pad value above any sample, so padded slots sort to the top.
    localparam logic [EXT_BITS-1:0] PAD_VALUE = EXT_BITS'(2 ** (SAMPLE_BITS - 1));

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [EXT_BITS-1:0]    ext_t;
    typedef logic [CNT_BITS-1:0]           cnt_t;
    typedef logic [IDX_BITS-1:0]           idx_t;

    // One window request: samples packed from slot 0, count of valid slots, final mark.
    typedef struct packed {
        logic [WIN_MAX-1:0][SAMPLE_BITS-1:0] win;
        cnt_t                                cnt;
        logic                                fin;
    } req_t;

    typedef enum logic {
        ST_RUN,
        ST_FLUSH
    } front_state_t;

endpackage
`default_nettype wire

FILE: rtl/etmf_front.sv
// Front end: takes samples, keeps the history and issues window requests.
// Depends on etmf_pkg.
`default_nettype none
module etmf_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire etmf_pkg::sample_t sample,
    input  wire logic             last,
    input  wire logic             sample_valid,
    output logic                  sample_ready,
    output logic                  push,
    output etmf_pkg::req_t        push_data,
    input  wire logic             full
);
    import etmf_pkg::*;

    sample_t      hist_reg [HIST_DEPTH];
    cnt_t         seen_reg;
    cnt_t         seen_next;
    front_state_t state_reg;
    front_state_t state_next;
    logic [WIN_MAX-1:0][SAMPLE_BITS-1:0] fl_win_reg;
    cnt_t         fl_n_reg;
    cnt_t         fl_q_reg;

    logic [WIN_MAX-1:0][SAMPLE_BITS-1:0] win_cur;
    logic [WIN_MAX-1:0][SAMPLE_BITS-1:0] win_sh;
    cnt_t         n_cur;
    cnt_t         start_q;
    cnt_t         fl_lo;
    logic         accept;
    logic         fl_end;

    assign n_cur   = seen_reg + cnt_t'(1);
    assign start_q = (seen_reg > cnt_t'(HALF_WIDTH)) ? seen_reg - cnt_t'(HALF_WIDTH) : '0;
    assign accept  = sample_valid && sample_ready;
    assign fl_lo   = (fl_q_reg > cnt_t'(HALF_WIDTH)) ? fl_q_reg - cnt_t'(HALF_WIDTH) : '0;
    assign fl_end  = (fl_q_reg == fl_n_reg - cnt_t'(1));

    always_comb
    begin
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            win_cur[i] = (cnt_t'(i) < seen_reg) ? hist_reg[i] : sample;
        end
        win_cur[HIST_DEPTH] = sample;
    end

    always_comb
    begin
        win_sh = fl_win_reg;
        for (int i = 0; i < WIN_MAX; i++)
        begin
            for (int l = 0; l <= HALF_WIDTH; l++)
            begin
                if ((fl_lo == cnt_t'(l)) && (i + l < WIN_MAX))
                begin
                    win_sh[i] = fl_win_reg[i + l];
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (accept && last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!full && fl_end)
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_comb
    begin
        sample_ready  = 1'b0;
        push          = 1'b0;
        push_data.win = win_cur;
        push_data.cnt = n_cur;
        push_data.fin = 1'b0;
        case (state_reg)
            ST_RUN:
            begin
                sample_ready = !full;
                push         = sample_valid && !full && !last
                               && (n_cur >= cnt_t'(HALF_WIDTH + 1));
            end
            ST_FLUSH:
            begin
                push          = !full;
                push_data.win = win_sh;
                push_data.cnt = fl_n_reg - fl_lo;
                push_data.fin = fl_end;
            end
            default:
            begin
                sample_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        seen_next = seen_reg;
        if (accept)
        begin
            if (last)
            begin
                seen_next = '0;
            end
            else if (seen_reg < cnt_t'(HIST_DEPTH))
            begin
                seen_next = seen_reg + cnt_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            seen_reg  <= '0;
            fl_n_reg  <= '0;
            fl_q_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
            if (accept && last)
            begin
                fl_n_reg <= n_cur;
                fl_q_reg <= start_q;
            end
            else if (state_reg == ST_FLUSH && !full)
            begin
                fl_q_reg <= fl_q_reg + cnt_t'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (last)
            begin
                fl_win_reg <= win_cur;
            end
            else if (seen_reg < cnt_t'(HIST_DEPTH))
            begin
                for (int i = 0; i < HIST_DEPTH; i++)
                begin
                    if (cnt_t'(i) == seen_reg)
                    begin
                        hist_reg[i] <= sample;
                    end
                end
            end
            else
            begin
                for (int i = 0; i < HIST_DEPTH - 1; i++)
                begin
                    hist_reg[i] <= hist_reg[i + 1];
                end
                hist_reg[HIST_DEPTH - 1] <= sample;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/etmf_fifo.sv
// Short request queue between front end and back end.
// Depends on etmf_pkg.
`default_nettype none
module etmf_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire etmf_pkg::req_t push_data,
    output logic               full,
    input  wire logic          pop,
    output etmf_pkg::req_t     pop_data,
    output logic               empty
);
    import etmf_pkg::*;

    req_t                  mem [Q_DEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg;
    logic [QPTR_BITS-1:0]  rd_ptr_reg;
    logic [QCNT_BITS-1:0]  count_reg;
    logic [QCNT_BITS-1:0]  count_next;

    assign full     = (count_reg == QCNT_BITS'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/etmf_back.sv
// Back end: pipelined odd-even transposition sort and middle-value pick (mean of the middle pair for an even count).
// Depends on etmf_pkg.
`default_nettype none
module etmf_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire etmf_pkg::req_t pop_data,
    input  wire logic          empty,
    output logic               pop,
    output etmf_pkg::sample_t  filtered,
    output logic               final_res,
    output logic               result_valid,
    input  wire logic          result_ready
);
    import etmf_pkg::*;

    ext_t    st_reg     [SORT_STAGES+1][WIN_MAX];
    cnt_t    st_cnt_reg [SORT_STAGES+1];
    logic    st_fin_reg [SORT_STAGES+1];
    logic    st_vld_reg [SORT_STAGES+1];
    ext_t    cx         [SORT_STAGES][WIN_MAX];
    ext_t    ld         [WIN_MAX];

    logic    out_vld_reg;
    sample_t out_val_reg;
    logic    out_fin_reg;

    logic    adv;
    idx_t    idx_a;
    idx_t    idx_b;
    ext_t    mid_a;
    ext_t    mid_b;
    logic signed [EXT_BITS:0] mid_sum;
    logic signed [EXT_BITS:0] mid_mean;

    assign adv          = !out_vld_reg || result_ready;
    assign pop          = adv && !empty;
    assign result_valid = out_vld_reg;
    assign filtered     = out_val_reg;
    assign final_res    = out_fin_reg;

    always_comb
    begin
        for (int i = 0; i < WIN_MAX; i++)
        begin
            if (cnt_t'(i) < pop_data.cnt)
            begin
                ld[i] = {pop_data.win[i][SAMPLE_BITS-1], pop_data.win[i]};
            end
            else
            begin
                ld[i] = PAD_VALUE;
            end
        end
    end

    always_comb
    begin
        for (int s = 0; s < SORT_STAGES; s++)
        begin
            for (int i = 0; i < WIN_MAX; i++)
            begin
                cx[s][i] = st_reg[s][i];
            end
            for (int i = s % 2; i + 1 < WIN_MAX; i += 2)
            begin
                if (st_reg[s][i] > st_reg[s][i + 1])
                begin
                    cx[s][i]     = st_reg[s][i + 1];
                    cx[s][i + 1] = st_reg[s][i];
                end
            end
        end
    end

    // Odd count: both picks land on the same slot.
    assign idx_a    = idx_t'((st_cnt_reg[SORT_STAGES] - cnt_t'(1)) >> 1);
    assign idx_b    = idx_t'(st_cnt_reg[SORT_STAGES] >> 1);
    assign mid_a    = st_reg[SORT_STAGES][idx_a];
    assign mid_b    = st_reg[SORT_STAGES][idx_b];
    assign mid_sum  = {mid_a[EXT_BITS-1], mid_a} + {mid_b[EXT_BITS-1], mid_b};
    assign mid_mean = mid_sum >>> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= SORT_STAGES; s++)
            begin
                st_vld_reg[s] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            st_vld_reg[0] <= pop;
            for (int s = 1; s <= SORT_STAGES; s++)
            begin
                st_vld_reg[s] <= st_vld_reg[s - 1];
            end
            out_vld_reg <= st_vld_reg[SORT_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < WIN_MAX; i++)
            begin
                st_reg[0][i] <= ld[i];
            end
            st_cnt_reg[0] <= pop_data.cnt;
            st_fin_reg[0] <= pop_data.fin;
            for (int s = 1; s <= SORT_STAGES; s++)
            begin
                for (int i = 0; i < WIN_MAX; i++)
                begin
                    st_reg[s][i] <= cx[s - 1][i];
                end
                st_cnt_reg[s] <= st_cnt_reg[s - 1];
                st_fin_reg[s] <= st_fin_reg[s - 1];
            end
            out_val_reg <= mid_mean[SAMPLE_BITS-1:0];
            out_fin_reg <= st_fin_reg[SORT_STAGES];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/edge_truncated_median_filter.sv
// Edge-truncated 7-tap median filter, top level.
// Throughput: one sample per cycle while the request queue has room; a sample marked
// last holds the input off while the front end issues its up to 4 flush windows.
// A queued request passes the queue, 7 sort stages and the median pick to its result;
// results trail the input stream by 3 samples.
// Reset clears control and the sample count; history contents are not cleared.
`default_nettype none
module edge_truncated_median_filter (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire etmf_pkg::sample_t sample,
    input  wire logic              last,
    input  wire logic              sample_valid,
    output logic                   sample_ready,
    output etmf_pkg::sample_t      filtered,
    output logic                   final_res,
    output logic                   result_valid,
    input  wire logic              result_ready
);
    import etmf_pkg::*;

    logic push;
    logic pop;
    logic full;
    logic empty;
    req_t push_data;
    req_t pop_data;

    etmf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .last         (last),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .push         (push),
        .push_data    (push_data),
        .full         (full)
    );

    etmf_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    etmf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_data     (pop_data),
        .empty        (empty),
        .pop          (pop),
        .filtered     (filtered),
        .final_res    (final_res),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("request pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("request popped from empty queue");

    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready && last) |=> !sample_ready)
        else $error("input taken during flush");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> !empty)
        else $error("pushed request lost");

endmodule
`default_nettype wire

FILE: verif/edge_truncated_median_filter_tb.sv
// Testbench for edge_truncated_median_filter: random and directed sample streams,
// checked result by result against an in-bench window-median predictor.
// Depends on rtl/etmf_pkg.sv and rtl/edge_truncated_median_filter.sv.
`timescale 1ns / 1ps
module edge_truncated_median_filter_tb;
    import etmf_pkg::*;

    localparam sample_t SAMPLE_MAX  = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam sample_t SAMPLE_MIN  = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
    localparam int      STALL_LIMIT = 2000;
    localparam int      LONG_HOLD   = 120;
    localparam int      DRAIN_WAIT  = 30;

    typedef struct packed {
        sample_t value;
        logic    fin;
    } flagged_sample_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    sample_t sample = '0;
    logic    last = 1'b0;
    logic    sample_valid = 1'b0;
    logic    sample_ready;
    sample_t filtered;
    logic    final_res;
    logic    result_valid;
    logic    result_ready = 1'b0;

    flagged_sample_t samples_to_send[$];
    flagged_sample_t medians_due[$];

    sample_t history_buf[HIST_DEPTH];
    int      history_cnt = 0;
    sample_t window_buf[WIN_MAX];

    bit in_taken = 1'b0;
    int items_total = 0;
    int streams_total = 0;
    int items_accepted = 0;
    int medians_checked = 0;
    int finals_checked = 0;
    int error_count = 0;
    int idle_cycles = 0;
    int send_gap = 0;
    int send_burst = 0;
    int hold_left = 0;
    int take_burst = 0;
    int long_holds = 0;

    edge_truncated_median_filter i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .last         (last),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .filtered     (filtered),
        .final_res    (final_res),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Median of window_buf[lo +: cnt]; even count takes floor of the middle pair mean.
    function automatic sample_t window_median(input int lo, input int cnt);
        sample_t                          sorted[WIN_MAX];
        sample_t                          v;
        logic signed [EXT_BITS-1:0]       pair_sum;
        int                               i;
        int                               j;
        for (i = 0; i < cnt; i++)
        begin
            v = window_buf[lo + i];
            j = i;
            while (j > 0 && sorted[j - 1] > v)
            begin
                sorted[j] = sorted[j - 1];
                j--;
            end
            sorted[j] = v;
        end
        if (cnt % 2 == 1)
            return sorted[cnt / 2];
        pair_sum = {sorted[(cnt - 1) / 2][SAMPLE_BITS-1], sorted[(cnt - 1) / 2]}
                 + {sorted[cnt / 2][SAMPLE_BITS-1], sorted[cnt / 2]};
        return pair_sum[EXT_BITS-1:1];
    endfunction

    task automatic predict_medians(input sample_t cur, input logic is_last);
        flagged_sample_t res;
        int              n;
        int              q;
        int              lo;
        int              i;
        for (i = 0; i < history_cnt; i++)
            window_buf[i] = history_buf[i];
        window_buf[history_cnt] = cur;
        n = history_cnt + 1;
        if (is_last)
        begin
            for (q = (n - 1 > HALF_WIDTH) ? n - 1 - HALF_WIDTH : 0; q < n; q++)
            begin
                lo = (q > HALF_WIDTH) ? q - HALF_WIDTH : 0;
                res.value = window_median(lo, n - lo);
                res.fin = (q == n - 1);
                medians_due.push_back(res);
            end
            history_cnt = 0;
        end
        else
        begin
            if (n >= HALF_WIDTH + 1)
            begin
                res.value = window_median(0, n);
                res.fin = 1'b0;
                medians_due.push_back(res);
            end
            if (history_cnt < HIST_DEPTH)
            begin
                history_buf[history_cnt] = cur;
                history_cnt++;
            end
            else
            begin
                for (i = 0; i < HIST_DEPTH - 1; i++)
                    history_buf[i] = history_buf[i + 1];
                history_buf[HIST_DEPTH - 1] = cur;
            end
        end
    endtask

    task automatic push_sample(input sample_t value, input logic fin);
        flagged_sample_t item;
        item.value = value;
        item.fin = fin;
        samples_to_send.push_back(item);
        items_total++;
        if (fin)
            streams_total++;
    endtask

    function automatic sample_t pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return SAMPLE_MAX;
        if (r < 16)
            return SAMPLE_MIN;
        if (r < 36)
            return sample_t'(int'($urandom_range(0, 15)) - 8);
        return sample_t'($urandom());
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(12, 30);
    endfunction

    // request driver
    always @(negedge clk)
    begin
        logic            offer;
        flagged_sample_t item;
        offer = sample_valid;
        if (rst_n)
        begin
            if (in_taken)
                offer = 1'b0;
            if (!offer)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (samples_to_send.size() > 0)
                begin
                    item = samples_to_send.pop_front();
                    sample <= item.value;
                    last <= item.fin;
                    offer = 1'b1;
                    if (send_burst > 0)
                    begin
                        send_burst--;
                        send_gap = 0;
                    end
                    else
                    begin
                        send_gap = draw_gap();
                        if ($urandom_range(0, 39) == 0)
                            send_burst = $urandom_range(20, 60);
                    end
                end
            end
        end
        sample_valid <= offer;
    end

    // result receiver
    always @(negedge clk)
    begin
        logic take;
        int   r;
        take = 1'b0;
        if (rst_n)
        begin
            if (hold_left > 0)
                hold_left--;
            else if (long_holds < 2 && medians_checked >= 100 + 200 * long_holds)
            begin
                long_holds++;
                hold_left = LONG_HOLD;
            end
            else if (take_burst > 0)
            begin
                take_burst--;
                take = 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                begin
                    take_burst = $urandom_range(20, 60);
                    take = 1'b1;
                end
                else if (r < 70)
                    take = 1'b1;
                else if (r < 93)
                    hold_left = $urandom_range(0, 2);
                else
                    hold_left = $urandom_range(5, 25);
            end
        end
        result_ready <= take;
    end

    // monitor, checker and watchdog
    always @(posedge clk)
    begin
        flagged_sample_t want;
        in_taken = 1'b0;
        if (rst_n)
        begin
            if (sample_valid && sample_ready)
            begin
                in_taken = 1'b1;
                items_accepted++;
                predict_medians(sample, last);
            end
            if (result_valid && result_ready)
            begin
                if (medians_due.size() == 0)
                begin
                    $error("unexpected result: filtered %0d final_res %0b", filtered, final_res);
                    error_count++;
                end
                else
                begin
                    want = medians_due.pop_front();
                    if (filtered !== want.value)
                    begin
                        $error("filtered: expected %0d, got %0d", want.value, filtered);
                        error_count++;
                    end
                    if (final_res !== want.fin)
                    begin
                        $error("final_res: expected %0b, got %0b", want.fin, final_res);
                        error_count++;
                    end
                    if (want.fin)
                        finals_checked++;
                end
                medians_checked++;
            end
            if (in_taken || (result_valid && result_ready))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("timeout: %0d samples accepted, %0d results outstanding",
                             items_accepted, medians_due.size());
                    $display("FAIL edge_truncated_median_filter");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int      len;
        int      i;
        sample_t v;

        push_sample(SAMPLE_MAX, 1'b1);
        push_sample(SAMPLE_MIN, 1'b1);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(SAMPLE_MAX, 1'b1);
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(SAMPLE_MAX, 1'b1);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(16'sd0, 1'b1);
        for (i = 0; i < 4; i++)
            push_sample((i % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN, i == 3);
        for (i = 0; i < 5; i++)
            push_sample(pick_sample(), i == 4);
        for (i = 0; i < 7; i++)
        begin
            case (i)
                0, 1, 4: v = SAMPLE_MIN;
                2, 3, 5: v = SAMPLE_MAX;
                default: v = -16'sd1;
            endcase
            push_sample(v, i == 6);
        end

        while (items_total < 490)
        begin
            len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 12) : $urandom_range(13, 60);
            for (i = 0; i < len; i++)
                push_sample(pick_sample(), i == len - 1);
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (items_accepted == items_total);
        wait (medians_due.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d samples in %0d streams sent, %0d medians checked (%0d stream ends)",
                 items_accepted, streams_total, medians_checked, finals_checked);
        $display("%0d long output holds applied, %0d mismatches", long_holds, error_count);
        if (error_count == 0 && medians_due.size() == 0)
            $display("PASS edge_truncated_median_filter");
        else
            $display("FAIL edge_truncated_median_filter");
        $finish;
    end

endmodule

FILE: edge_truncated_median_filter.f
rtl/etmf_pkg.sv
rtl/etmf_front.sv
rtl/etmf_fifo.sv
rtl/etmf_back.sv
rtl/edge_truncated_median_filter.sv
verif/edge_truncated_median_filter_tb.sv
